// ----- hdl/quaternion_multiply_rotate_assert.svh -----
// Assertion macros shared by the quaternion multiply/rotate RTL.
// Assertions are sampled on clk and are held off while rst_n is low.
// Defining ASSERT_OFF leaves the macros with an empty body.
`ifndef QUATERNION_MULTIPLY_ROTATE_ASSERT_SVH
`define QUATERNION_MULTIPLY_ROTATE_ASSERT_SVH
`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define QMR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("quaternion_multiply_rotate: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define QMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("quaternion_multiply_rotate: next-cycle check failed");
`else
`define QMR_ASSERT_IMPL(label, ante, cons)
`define QMR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hdl/qmr_pkg.sv -----
// Shared types and constants for the quaternion multiply/rotate block.
// Holds component indexes, the request kind and the Hamilton term tables.
// No dependencies.
package qmr_pkg;

  // Component index within a quaternion.
  typedef logic [1:0] comp_idx_t;

  localparam comp_idx_t X_IDX = 2'd0;
  localparam comp_idx_t Y_IDX = 2'd1;
  localparam comp_idx_t Z_IDX = 2'd2;
  localparam comp_idx_t W_IDX = 2'd3;

  // Request kind carried with each input item.
  typedef enum logic {
    REQ_MULTIPLY = 1'b0,
    REQ_ROTATE   = 1'b1
  } req_type_t;

  // Hamilton product terms: for result component k and term t, the left
  // operand component, the right operand component and whether it is subtracted.
  localparam comp_idx_t TERM_A [4][4] = '{
    '{W_IDX, X_IDX, Y_IDX, Z_IDX},
    '{W_IDX, X_IDX, Y_IDX, Z_IDX},
    '{W_IDX, X_IDX, Y_IDX, Z_IDX},
    '{W_IDX, X_IDX, Y_IDX, Z_IDX}
  };

  localparam comp_idx_t TERM_B [4][4] = '{
    '{X_IDX, W_IDX, Z_IDX, Y_IDX},
    '{Y_IDX, Z_IDX, W_IDX, X_IDX},
    '{Z_IDX, Y_IDX, X_IDX, W_IDX},
    '{W_IDX, X_IDX, Y_IDX, Z_IDX}
  };

  localparam bit TERM_N [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

endpackage

// ----- hdl/qmr_channels.sv -----
// Valid/ready channel interfaces for the quaternion multiply/rotate block.
// qmr_in_if carries one request item, qmr_out_if one result item.
// Depends on nothing; widths follow the DATA_WIDTH parameter.
interface qmr_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [DATA_WIDTH-1:0] left_x;
  logic signed [DATA_WIDTH-1:0] left_y;
  logic signed [DATA_WIDTH-1:0] left_z;
  logic signed [DATA_WIDTH-1:0] left_w;
  logic signed [DATA_WIDTH-1:0] right_x;
  logic signed [DATA_WIDTH-1:0] right_y;
  logic signed [DATA_WIDTH-1:0] right_z;
  logic signed [DATA_WIDTH-1:0] right_w;

  modport source (
    output valid, req_type, left_x, left_y, left_z, left_w,
    output right_x, right_y, right_z, right_w,
    input  ready
  );
  modport sink (
    input  valid, req_type, left_x, left_y, left_z, left_w,
    input  right_x, right_y, right_z, right_w,
    output ready
  );
endinterface

interface qmr_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic signed [DATA_WIDTH-1:0] out_w;
  logic                         saturated;

  modport source (
    output valid, out_x, out_y, out_z, out_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, out_w, saturated,
    output ready
  );
endinterface

// ----- hdl/qmr_hamilton.sv -----
// Five-stage pipelined Hamilton product a * b with round-half-up and saturation.
// Carries a sideband word alongside each item. Depends on qmr_pkg.
// Each stage has its own valid bit and loads when it is empty or the stage after it can move.
module qmr_hamilton #(
  parameter int DW   = 32,
  parameter int FB   = 16,
  parameter int SB_W = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_conj,
  input  logic [3:0][DW-1:0]       in_a,
  input  logic [3:0][DW-1:0]       in_b,
  input  logic [SB_W-1:0]          in_sb,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [3:0][DW-1:0]       out_res,
  output logic [3:0]               out_clip,
  output logic [SB_W-1:0]          out_sb
);
  import qmr_pkg::*;

  localparam int NST   = 5;
  localparam int LW    = DW / 2;
  localparam int HW    = DW - LW;
  localparam int PW    = 2 * DW;
  localparam int ACC_W = 2 * DW + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FB - 1);
  localparam logic signed [DW-1:0]    SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0]    SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // Stage control: valid bits and the load chain running back from the output.
  logic [NST:1]   v_r;
  logic [NST+1:1] ld;
  logic [SB_W-1:0] sb_r [NST];

  // Stage 1: partial products of split operands.
  logic signed [2*HW-1:0]    hh_nxt [16], hh_r [16];
  logic signed [HW+LW:0]     hl_nxt [16], hl_r [16];
  logic signed [HW+LW:0]     lh_nxt [16], lh_r [16];
  logic        [2*LW-1:0]    ll_nxt [16], ll_r [16];
  logic                      neg1_nxt [16], neg1_r [16];
  // Stage 2: full products.
  logic signed [PW-1:0]      prod_nxt [16], prod_r [16];
  logic                      neg2_r [16];
  // Stage 3: pairwise signed sums.
  logic signed [ACC_W-1:0]   s01_nxt [4], s01_r [4];
  logic signed [ACC_W-1:0]   s23_nxt [4], s23_r [4];
  // Stage 4: full sum with rounding constant.
  logic signed [ACC_W-1:0]   acc_nxt [4], acc_r [4];
  // Stage 5: rounded and saturated result.
  logic [3:0][DW-1:0]        res_nxt, res_r;
  logic [3:0]                clip_nxt, clip_r;

  // A stage may load when it is empty or its content moves on.
  always_comb begin
    ld[NST+1] = out_ready;
    for (int k = NST; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign in_ready = ld[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Sideband travels in step with the data.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      sb_r[0] <= in_sb;
    end
    for (int k = 1; k < NST; k++) begin
      if (ld[k+1]) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // Stage 1: each operand is split into a signed high half and an unsigned
  // low half so that no multiplier is wider than about half a word plus one.
  always_comb begin
    logic signed [HW-1:0] a_hi, b_hi;
    logic [LW-1:0]        a_lo, b_lo;
    comp_idx_t            ai, bi;
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 4; t++) begin
        ai = TERM_A[k][t];
        bi = TERM_B[k][t];
        a_hi = in_a[ai][DW-1:LW];
        a_lo = in_a[ai][LW-1:0];
        b_hi = in_b[bi][DW-1:LW];
        b_lo = in_b[bi][LW-1:0];
        hh_nxt[k*4+t]   = a_hi * b_hi;
        hl_nxt[k*4+t]   = a_hi * $signed({1'b0, b_lo});
        lh_nxt[k*4+t]   = $signed({1'b0, a_lo}) * b_hi;
        ll_nxt[k*4+t]   = a_lo * b_lo;
        // The conjugate flips every term whose right component is a vector part.
        neg1_nxt[k*4+t] = TERM_N[k][t] ^ (in_conj && (bi != W_IDX));
      end
    end
  end

  // Stage 2: recombine the partial products into the exact product.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      prod_nxt[i] = (PW'(hh_r[i]) <<< (2 * LW)) + (PW'(hl_r[i]) <<< LW)
                  + (PW'(lh_r[i]) <<< LW) + PW'(ll_r[i]);
    end
  end

  // Stage 3: apply term signs and add the terms in pairs.
  always_comb begin
    logic signed [ACC_W-1:0] term [16];
    for (int i = 0; i < 16; i++) begin
      term[i] = neg2_r[i] ? -ACC_W'(prod_r[i]) : ACC_W'(prod_r[i]);
    end
    for (int k = 0; k < 4; k++) begin
      s01_nxt[k] = term[k*4]   + term[k*4+1];
      s23_nxt[k] = term[k*4+2] + term[k*4+3];
    end
  end

  // Stage 4: complete the sum with half an LSB added for round-half-up.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      acc_nxt[k] = s01_r[k] + s23_r[k] + HALF;
    end
  end

  // Stage 5: drop the fraction bits and clip to the signed output range.
  always_comb begin
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-DW:0]       top;
    for (int k = 0; k < 4; k++) begin
      sh  = acc_r[k] >>> FB;
      top = sh[ACC_W-1:DW-1];
      clip_nxt[k] = !((&top) || !(|top));
      if (!clip_nxt[k]) begin
        res_nxt[k] = sh[DW-1:0];
      end else if (acc_r[k][ACC_W-1]) begin
        res_nxt[k] = SAT_MIN;
      end else begin
        res_nxt[k] = SAT_MAX;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (ld[1]) begin
      hh_r   <= hh_nxt;
      hl_r   <= hl_nxt;
      lh_r   <= lh_nxt;
      ll_r   <= ll_nxt;
      neg1_r <= neg1_nxt;
    end
    if (ld[2]) begin
      prod_r <= prod_nxt;
      neg2_r <= neg1_r;
    end
    if (ld[3]) begin
      s01_r <= s01_nxt;
      s23_r <= s23_nxt;
    end
    if (ld[4]) begin
      acc_r <= acc_nxt;
    end
    if (ld[5]) begin
      res_r  <= res_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign out_valid = v_r[NST];
  assign out_res   = res_r;
  assign out_clip  = clip_r;
  assign out_sb    = sb_r[NST-1];

endmodule

// ----- hdl/quaternion_multiply_rotate.sv -----
// Quaternion multiply/rotate: takes one item per clock while the output is not
// stalled and returns one result item per item, through two 5-stage Hamilton
// product pipelines and an output register. Multiply returns left * right;
// rotate returns the vector part of (left * v) * conj(left), with out_w zero. All
// sums are exact, rounded half up and saturated; saturated flags any clipping that
// feeds the result. Every stage holds its own valid bit, so stalls fill bubbles and
// lose nothing. Depends on qmr_pkg, qmr_channels, qmr_hamilton and the assertion header.
`include "quaternion_multiply_rotate_assert.svh"

module quaternion_multiply_rotate #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qmr_in_if.sink    in_ch,
  qmr_out_if.source out_ch
);
  import qmr_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int SB_A_W = 1 + 4 * DW;
  localparam int SB_B_W = 2 + 4 * DW;

  // First product: t = left * right, or left * (v, 0) for rotate.
  logic [3:0][DW-1:0] a_left, a_right, a_res;
  logic [3:0]         a_clip;
  logic [SB_A_W-1:0]  a_sb_in, a_sb_out;
  logic               a_valid, a_ready;
  logic               in_rot;

  // Second product: t * conj(left) for rotate.
  logic [3:0][DW-1:0] b_left, b_res, b_fwd;
  logic [3:0]         b_clip;
  logic [SB_B_W-1:0]  b_sb_in, b_sb_out;
  logic               b_valid, b_ready, b_conj;
  logic               b_rot, b_sat_first;

  // Output register.
  logic               out_valid_r;
  logic               out_rot_r;
  logic [3:0][DW-1:0] out_q_nxt, out_q_r;
  logic               out_sat_nxt, out_sat_r;
  logic               out_ld;

  assign in_rot = (in_ch.req_type == REQ_ROTATE);

  // Operand packing for the first product.
  always_comb begin
    a_left[X_IDX]  = in_ch.left_x;
    a_left[Y_IDX]  = in_ch.left_y;
    a_left[Z_IDX]  = in_ch.left_z;
    a_left[W_IDX]  = in_ch.left_w;
    a_right[X_IDX] = in_ch.right_x;
    a_right[Y_IDX] = in_ch.right_y;
    a_right[Z_IDX] = in_ch.right_z;
    a_right[W_IDX] = in_rot ? '0 : in_ch.right_w;
  end

  assign a_sb_in = {in_rot, a_left};

  qmr_hamilton #(
    .DW   (DW),
    .FB   (FRAC_BITS),
    .SB_W (SB_A_W)
  ) u_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_conj   (1'b0),
    .in_a      (a_left),
    .in_b      (a_right),
    .in_sb     (a_sb_in),
    .out_valid (a_valid),
    .out_ready (a_ready),
    .out_res   (a_res),
    .out_clip  (a_clip),
    .out_sb    (a_sb_out)
  );

  // The second product always runs; for multiply its result is dropped and the
  // first product rides along in the sideband.
  assign b_left  = a_sb_out[4*DW-1:0];
  assign b_conj  = a_sb_out[SB_A_W-1];
  assign b_sb_in = {b_conj, |a_clip, a_res};

  qmr_hamilton #(
    .DW   (DW),
    .FB   (FRAC_BITS),
    .SB_W (SB_B_W)
  ) u_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_conj   (b_conj),
    .in_a      (a_res),
    .in_b      (b_left),
    .in_sb     (b_sb_in),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_res   (b_res),
    .out_clip  (b_clip),
    .out_sb    (b_sb_out)
  );

  assign b_rot       = b_sb_out[SB_B_W-1];
  assign b_sat_first = b_sb_out[SB_B_W-2];
  assign b_fwd       = b_sb_out[4*DW-1:0];

  // Result selection; the scalar of the rotated product is discarded.
  always_comb begin
    if (b_rot) begin
      out_q_nxt[X_IDX] = b_res[X_IDX];
      out_q_nxt[Y_IDX] = b_res[Y_IDX];
      out_q_nxt[Z_IDX] = b_res[Z_IDX];
      out_q_nxt[W_IDX] = '0;
      out_sat_nxt      = b_sat_first || (|b_clip[Z_IDX:X_IDX]);
    end else begin
      out_q_nxt        = b_fwd;
      out_sat_nxt      = b_sat_first;
    end
  end

  assign out_ld  = !out_valid_r || out_ch.ready;
  assign b_ready = out_ld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_q_r   <= out_q_nxt;
      out_sat_r <= out_sat_nxt;
      out_rot_r <= b_rot;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_q_r[X_IDX];
  assign out_ch.out_y     = out_q_r[Y_IDX];
  assign out_ch.out_z     = out_q_r[Z_IDX];
  assign out_ch.out_w     = out_q_r[W_IDX];
  assign out_ch.saturated = out_sat_r;

  // A rotate result never carries a scalar.
  `QMR_ASSERT_IMPL(a_rotate_w_zero, out_valid_r && out_rot_r, out_q_r[W_IDX] == '0)
  // Input back-pressure only arises when the output is held.
  `QMR_ASSERT_IMPL(a_stall_source, !in_ch.ready, out_valid_r && !out_ch.ready)
  // An item handed out of the second product lands in the output register.
  `QMR_ASSERT_NEXT(a_handoff, b_valid && out_ld, out_valid_r)

endmodule
